/* hw/rtl/sensor_data_packet_deframer_core_assert.svh */
// Assertion macros used by the deframer back end.
// They expect clk and rst_n in scope.
`ifndef SENSOR_DATA_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define SENSOR_DATA_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SDPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdpd assertion failed");

// Next-cycle implication.
`define SDPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdpd assertion failed");

`endif

/* hw/rtl/sdpd_pkg.sv */
package sdpd_pkg;

  localparam int MAX_PAYLOAD   = 64;
  localparam int STORE_AW      = $clog2(MAX_PAYLOAD);
  localparam int FRAME_EXTRA   = 11;
  localparam int SUM_START     = 6;
  localparam int PAYLOAD_START = 9;
  localparam logic [7:0] END_FLAG = 8'h08;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);

  // Input kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_NOEND   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_PAYLOAD_SIZE = 2'd0;
  localparam logic [1:0] REG_EXPECTED     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;

  localparam logic [6:0]  RST_PAYLOAD_SIZE = 7'd64;
  localparam logic [15:0] RST_EXPECTED     = 16'd1;
  localparam logic [19:0] RST_TIMEOUT      = 20'd300000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  payload_size;
    logic [15:0] expected_packets;
    logic [19:0] timeout_ticks;
  } cfg_t;

  // Work handed from front to back
  typedef struct packed {
    logic       is_emit;
    logic [6:0] psize;
    logic       done;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

/* hw/rtl/sdpd_front.sv */
module sdpd_front
  import sdpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  input  logic      back_pending,
  input  logic      cmd_full,
  output logic      cmd_push,
  output cmd_t      cmd,
  output store_wr_t store_wr
);

  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] pkts_r, pkts_nxt;
  logic [19:0] idle_r, idle_nxt;
  logic        fin_r, fin_nxt;

  logic        accept;
  logic [6:0]  psize;
  logic [7:0]  total;
  logic [7:0]  pos_p2;
  logic [15:0] pkts_inc;

  // stall on a full command queue, and from the payload on while the back end has work
  assign full   = cmd_full || (back_pending && (pos_r >= 7'(PAYLOAD_START)));
  assign accept = push && !full;

  always_comb begin
    if (cfg.payload_size == 7'd0) begin
      psize = 7'd1;
    end else if (cfg.payload_size > 7'(MAX_PAYLOAD)) begin
      psize = 7'(MAX_PAYLOAD);
    end else begin
      psize = cfg.payload_size;
    end
  end

  assign total    = {1'b0, psize} + 8'(FRAME_EXTRA);
  assign pos_p2   = {1'b0, pos_r} + 8'd2;
  assign pkts_inc = (pkts_r == 16'hFFFF) ? pkts_r : pkts_r + 16'd1;

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    flag_nxt = flag_r;
    hi_nxt   = hi_r;
    pkts_nxt = pkts_r;
    idle_nxt = idle_r;
    fin_nxt  = fin_r;
    cmd_push = 1'b0;
    cmd      = '0;
    store_wr.we   = 1'b0;
    store_wr.addr = STORE_AW'(pos_r - 7'(PAYLOAD_START));
    store_wr.data = in_item.rx_byte;
    if (accept) begin
      if (in_item.kind == KIND_START) begin
        pos_nxt  = '0;
        sum_nxt  = '0;
        flag_nxt = '0;
        hi_nxt   = '0;
        pkts_nxt = '0;
        idle_nxt = '0;
        fin_nxt  = 1'b0;
      end else if (!fin_r && in_item.kind == KIND_TICK) begin
        if (idle_r >= cfg.timeout_ticks) begin
          fin_nxt    = 1'b1;
          cmd_push   = 1'b1;
          cmd.done   = 1'b1;
          cmd.status = ST_TIMEOUT;
        end else begin
          idle_nxt = idle_r + 20'd1;
        end
      end else if (!fin_r && in_item.kind == KIND_BYTE) begin
        idle_nxt = '0;
        if (pos_p2 < total) begin
          if (pos_r >= 7'(SUM_START)) begin
            sum_nxt = sum_r + 16'(in_item.rx_byte);
          end
          if (pos_r == 7'(SUM_START)) begin
            flag_nxt = in_item.rx_byte;
          end
          store_wr.we = (pos_r >= 7'(PAYLOAD_START));
          pos_nxt = pos_r + 7'd1;
        end else if (pos_p2 == total) begin
          hi_nxt  = in_item.rx_byte;
          pos_nxt = pos_r + 7'd1;
        end else begin
          pos_nxt  = '0;
          sum_nxt  = '0;
          flag_nxt = '0;
          hi_nxt   = '0;
          cmd_push = 1'b1;
          if ({hi_r, in_item.rx_byte} != sum_r) begin
            fin_nxt    = 1'b1;
            cmd.done   = 1'b1;
            cmd.status = ST_CSUM;
          end else begin
            pkts_nxt    = pkts_inc;
            cmd.is_emit = 1'b1;
            cmd.psize   = psize;
            if (flag_r == END_FLAG) begin
              cmd.done   = 1'b1;
              cmd.status = (pkts_inc >= cfg.expected_packets) ? ST_OK : ST_TIMEOUT;
            end else if (pkts_inc >= cfg.expected_packets) begin
              cmd.done   = 1'b1;
              cmd.status = ST_NOEND;
            end
            fin_nxt = cmd.done;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      flag_r <= '0;
      hi_r   <= '0;
      pkts_r <= '0;
      idle_r <= '0;
      fin_r  <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      flag_r <= flag_nxt;
      hi_r   <= hi_nxt;
      pkts_r <= pkts_nxt;
      idle_r <= idle_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

/* hw/rtl/sdpd_cmd_fifo.sv */
module sdpd_cmd_fifo
  import sdpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t            mem_r [CMD_DEPTH];
  logic [CMD_PW-1:0] wp_r, wp_nxt;
  logic [CMD_PW-1:0] rp_r, rp_nxt;
  logic [CMD_PW:0]   cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full   = (cnt_r == (CMD_PW+1)'(CMD_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? CMD_PW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? CMD_PW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (CMD_PW+1)'(do_wr) - (CMD_PW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/sdpd_back.sv */
`include "sensor_data_packet_deframer_core_assert.svh"

module sdpd_back
  import sdpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  store_wr_t store_wr,
  input  cmd_t      cmd_head,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output logic      busy,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_LD   = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [STORE_AW-1:0] k_r, k_nxt;
  logic [7:0]          store_r [MAX_PAYLOAD];
  logic [7:0]          rdata_r;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                is_last;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign out_free = !out_valid_r || pop;
  assign busy     = (state_r != S_IDLE);
  assign is_last  = (7'(k_r) + 7'd1 == cmd_r.psize);

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      store_r[store_wr.addr] <= store_wr.data;
    end
    rdata_r <= store_r[k_r];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    cmd_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty && out_free) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_head;
          k_nxt   = '0;
          if (cmd_head.is_emit) begin
            state_nxt = S_RD;
          end else begin
            out_nxt.data_byte  = '0;
            out_nxt.data_valid = 1'b0;
            out_nxt.done_res   = 1'b1;
            out_nxt.status     = cmd_head.status;
            out_nxt.last       = 1'b1;
            out_valid_nxt      = 1'b1;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_nxt.data_byte  = rdata_r;
          out_nxt.data_valid = 1'b1;
          out_nxt.done_res   = is_last && cmd_r.done;
          out_nxt.status     = (is_last && cmd_r.done) ? cmd_r.status : ST_OK;
          out_nxt.last       = is_last;
          out_valid_nxt      = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  `SDPD_ASSERT_IMPL(a_nodata_is_done, out_valid_r && !out_r.data_valid, out_r.data_byte == 8'd0 && out_r.done_res && out_r.last)
  `SDPD_ASSERT_IMPL(a_done_on_last, out_valid_r && out_r.done_res, out_r.last)
  `SDPD_ASSERT_IMPL(a_k_in_range, state_r != S_IDLE, 7'(k_r) < cmd_r.psize)
  `SDPD_ASSERT_NEXT(a_pop_starts, cmd_pop && cmd_head.is_emit, state_r == S_RD && k_r == '0)

endmodule

/* hw/rtl/sensor_data_packet_deframer_core.sv */
// A good packet's command is queued once its last byte is accepted; the back end
// then reads each payload byte from the 64-entry store (S_RD) and loads it into the
// output register (S_LD); this registered read sets the rate of results. Input
// stalls if the command queue is full, or from the payload on while work is pending.
// Reset (rst_n low, synchronous): transfer finished (idle until a start item),
// counters clear, registers return to 64 / 1 / 300000; the store is not cleared.
module sensor_data_packet_deframer_core
  import sdpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input queue
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  // result queue
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  cmd_t      cmd_in, cmd_head;
  logic      cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic      back_busy;
  store_wr_t store_wr;

  // Register file: write in the access phase, reads are combinational.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAYLOAD_SIZE: cfg_nxt.payload_size     = pwdata[6:0];
        REG_EXPECTED:     cfg_nxt.expected_packets = pwdata[15:0];
        REG_TIMEOUT:      cfg_nxt.timeout_ticks    = pwdata[19:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAYLOAD_SIZE: prdata = {25'd0, cfg_r.payload_size};
      REG_EXPECTED:     prdata = {16'd0, cfg_r.expected_packets};
      REG_TIMEOUT:      prdata = {12'd0, cfg_r.timeout_ticks};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_size     <= RST_PAYLOAD_SIZE;
      cfg_r.expected_packets <= RST_EXPECTED;
      cfg_r.timeout_ticks    <= RST_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: framing, checksum, packet count, idle timer; posts work for the back.
  sdpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .push         (push),
    .full         (full),
    .in_item      (in_item),
    .back_pending (back_busy || !cmd_empty),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .store_wr     (store_wr)
  );

  // Short command queue decouples the two halves.
  sdpd_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_head),
    .empty  (cmd_empty)
  );

  // Back: owns the payload store, streams items into the output register.
  sdpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .store_wr  (store_wr),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .busy      (back_busy),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
